/* sv/sliding_window_median_macros.svh */
// Assertion helpers for the running median block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/swm_pkg.sv */
package swm_pkg;

  // Width of one sample and of the median.
  localparam int VAL_W = 16;

  // Default window length.
  localparam int WIN_LEN_DEF = 9;

  // Per-cycle commands from the sequencer to the window store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic flip;
  } mem_ctl_t;

endpackage

/* sv/swm_window.sv */
module swm_window #(
  parameter int WIN_LEN = swm_pkg::WIN_LEN_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  swm_pkg::mem_ctl_t                       mem_ctl,
  input  logic [$clog2(WIN_LEN)-1:0]              rd_addr,
  input  logic [$clog2(WIN_LEN)-1:0]              wr_addr,
  input  logic [$clog2(WIN_LEN)+swm_pkg::VAL_W-1:0] wr_data,
  output logic [$clog2(WIN_LEN)+swm_pkg::VAL_W-1:0] rd_data
);

  localparam int EW = $clog2(WIN_LEN) + swm_pkg::VAL_W;

  // Two banks: the live window is read from the active bank while the
  // re-sorted window is written into the other one, so a read and a write
  // never touch the same entry.
  logic [EW-1:0] mem0_r [WIN_LEN];
  logic [EW-1:0] mem1_r [WIN_LEN];
  logic [EW-1:0] rd_data_r;
  logic          bank_r;
  logic          bank_nxt;

  assign bank_nxt = mem_ctl.flip ? ~bank_r : bank_r;
  assign rd_data  = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else begin
      bank_r <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      if (bank_r) begin
        mem0_r[wr_addr] <= wr_data;
      end else begin
        mem1_r[wr_addr] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= bank_r ? mem1_r[rd_addr] : mem0_r[rd_addr];
    end
  end

endmodule

/* sv/swm_ctrl.sv */
module swm_ctrl #(
  parameter int WIN_LEN = swm_pkg::WIN_LEN_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_vld,
  output logic                                      in_rdy,
  input  logic                                      in_conn,
  input  logic signed [swm_pkg::VAL_W-1:0]          in_val,
  output logic                                      res_vld,
  input  logic                                      res_rdy,
  output logic signed [swm_pkg::VAL_W-1:0]          res_med,
  output swm_pkg::mem_ctl_t                         mem_ctl,
  output logic [$clog2(WIN_LEN)-1:0]                rd_addr,
  output logic [$clog2(WIN_LEN)-1:0]                wr_addr,
  output logic [$clog2(WIN_LEN)+swm_pkg::VAL_W-1:0] wr_data,
  input  logic [$clog2(WIN_LEN)+swm_pkg::VAL_W-1:0] rd_data
);

  localparam int VW  = swm_pkg::VAL_W;
  localparam int IW  = $clog2(WIN_LEN);
  localparam int CW  = $clog2(WIN_LEN + 1);
  localparam int AW  = IW;
  localparam int MID = WIN_LEN / 2;

  localparam logic [CW-1:0] K_LAST   = CW'(WIN_LEN - 1);
  localparam logic [CW-1:0] K_END    = CW'(WIN_LEN);
  localparam logic [CW-1:0] K_MID    = CW'(MID);
  localparam logic [AW-1:0] AGE_LAST = AW'(WIN_LEN - 1);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_COPY = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic                 primed_r, primed_nxt;
  logic                 repl_r, repl_nxt;
  logic signed [VW-1:0] v_r, v_nxt;
  logic [CW-1:0]        s_r, s_nxt;
  logic [CW-1:0]        l_r, l_nxt;
  logic [CW-1:0]        t_r, t_nxt;
  logic                 seen_r, seen_nxt;
  logic                 hit_r, hit_nxt;
  logic signed [VW-1:0] med_r, med_nxt;

  logic signed [VW-1:0] rd_val;
  logic [AW-1:0]        rd_age;
  logic [CW-1:0]        j;
  logic                 in_blk;
  logic                 below;
  logic [CW:0]          kx, sx, lx, tx, tlx, rx, src_x;
  logic                 src_hit;
  logic signed [VW-1:0] new_val;
  logic [AW-1:0]        new_age;

  assign rd_val = rd_data[VW-1:0];
  assign rd_age = rd_data[AW+VW-1:VW];
  assign j      = k_r - 1'b1;

  // The block being moved: the oldest entry when primed, otherwise the
  // run of zero entries, which is contiguous because the window is sorted.
  assign in_blk = repl_r ? (rd_age == AGE_LAST) : (rd_val == '0);
  // Entries that end up ahead of the block in a stable sort.
  assign below  = (rd_val < v_r) || ((rd_val == v_r) && !seen_r);

  // Source index for output slot k when the block [s, s+l) is pulled out
  // of the window and dropped back in at slot t.
  always_comb begin
    kx      = {1'b0, k_r};
    sx      = {1'b0, s_r};
    lx      = {1'b0, l_r};
    tx      = {1'b0, t_r};
    tlx     = tx + lx;
    rx      = kx - lx;
    src_hit = 1'b0;
    if (kx < tx) begin
      src_x = (kx < sx) ? kx : kx + lx;
    end else if (kx < tlx) begin
      src_x   = sx + kx - tx;
      src_hit = 1'b1;
    end else begin
      src_x = (rx < sx) ? rx : rx + lx;
    end
  end

  assign new_val = hit_r ? v_r : rd_val;
  assign new_age = repl_r ? (hit_r ? '0 : rd_age + 1'b1) : rd_age;

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    primed_nxt = primed_r;
    repl_nxt   = repl_r;
    v_nxt      = v_r;
    s_nxt      = s_r;
    l_nxt      = l_r;
    t_nxt      = t_r;
    seen_nxt   = seen_r;
    hit_nxt    = hit_r;
    med_nxt    = med_r;
    in_rdy     = 1'b0;
    res_vld    = 1'b0;
    mem_ctl    = '0;
    rd_addr    = k_r[IW-1:0];
    wr_addr    = k_r[IW-1:0];
    wr_data    = {k_r[AW-1:0], {VW{1'b0}}};

    unique case (state_r)
      ST_INIT: begin
        // Clearing pass: entry i gets value zero and age i.
        mem_ctl.wr_en = 1'b1;
        if (k_r == K_LAST) begin
          mem_ctl.flip = 1'b1;
          k_nxt        = '0;
          state_nxt    = ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_vld) begin
          v_nxt = in_val;
          if (!in_conn) begin
            primed_nxt = 1'b0;
            med_nxt    = '0;
            state_nxt  = ST_FIN;
          end else begin
            repl_nxt   = primed_r;
            primed_nxt = 1'b1;
            s_nxt      = '0;
            l_nxt      = '0;
            t_nxt      = '0;
            seen_nxt   = 1'b0;
            k_nxt      = '0;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (k_r != K_END) begin
          mem_ctl.rd_en = 1'b1;
        end
        if (k_r != '0) begin
          if (in_blk) begin
            if (!seen_r) begin
              s_nxt = j;
            end
            seen_nxt = 1'b1;
            l_nxt    = l_r + 1'b1;
          end else if (below) begin
            t_nxt = t_r + 1'b1;
          end
        end
        if (k_r == K_END) begin
          k_nxt     = '0;
          state_nxt = ST_COPY;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_COPY: begin
        if (k_r != K_END) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = src_x[IW-1:0];
          hit_nxt       = src_hit;
        end
        if (k_r != '0) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = j[IW-1:0];
          wr_data       = {new_age, new_val};
          if (j == K_MID) begin
            med_nxt = new_val;
          end
        end
        if (k_r == K_END) begin
          mem_ctl.flip = 1'b1;
          k_nxt        = '0;
          state_nxt    = ST_FIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_FIN: begin
        res_vld = 1'b1;
        if (res_rdy) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_med = med_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      k_r      <= '0;
      primed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      primed_r <= primed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    repl_r <= repl_nxt;
    v_r    <= v_nxt;
    s_r    <= s_nxt;
    l_r    <= l_nxt;
    t_r    <= t_nxt;
    seen_r <= seen_nxt;
    hit_r  <= hit_nxt;
    med_r  <= med_nxt;
  end

endmodule

/* sv/sliding_window_median.sv */
// Running median of a stream of signed 16-bit sensor samples over a window
// of WIN_LEN entries. One input word carries a sample in in_tdata and the
// link status in in_tuser; every accepted input word yields exactly one
// output word holding the median in out_tdata.
// A word taken while the link is down yields zero, leaves the window alone
// and re-arms the first-sample fill. The first word after that fills every
// zero entry of the window; later words replace the oldest entry.
// A connected word runs one scan pass and one copy pass over the window
// memory, one entry per cycle each, before its median is handed to the
// output register; a disconnected word skips both passes. No new word is
// taken while the block is busy with the last one.
// After reset the block writes the initial window, all WIN_LEN entries,
// into its memory with in_tready low.
// The result sits in an output register, so a new word may be taken while
// the receiver stalls; the block then holds its next result and in_tready
// stays low until the output register is free.
`include "sliding_window_median_macros.svh"

module sliding_window_median #(
  parameter int WIN_LEN = swm_pkg::WIN_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: sample_value [15:0]
  input  logic signed [swm_pkg::VAL_W-1:0]  in_tdata,
  // in_tuser: sensor_connected [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: median_out [15:0]
  output logic signed [swm_pkg::VAL_W-1:0]  out_tdata
);

  localparam int IW = $clog2(WIN_LEN);
  localparam int EW = IW + swm_pkg::VAL_W;

  // Hand-off between the sequencer and the output register.
  logic                             res_vld;
  logic                             res_rdy;
  logic signed [swm_pkg::VAL_W-1:0] res_med;

  // Window memory access.
  swm_pkg::mem_ctl_t mem_ctl;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [EW-1:0]     rd_data;

  logic                             out_tvalid_r, out_tvalid_nxt;
  logic signed [swm_pkg::VAL_W-1:0] out_tdata_r, out_tdata_nxt;

  // The sequencer scans the sorted window to find the block to move and its
  // new slot, then copies the window into the spare bank in sorted order.
  swm_ctrl #(
    .WIN_LEN (WIN_LEN)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_tvalid),
    .in_rdy  (in_tready),
    .in_conn (in_tuser),
    .in_val  (in_tdata),
    .res_vld (res_vld),
    .res_rdy (res_rdy),
    .res_med (res_med),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  swm_window #(
    .WIN_LEN (WIN_LEN)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // The output register takes a new result when it is empty or when its
  // current word leaves in the same cycle.
  assign res_rdy = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (res_vld && res_rdy) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = res_med;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A word taken while the link is down produces a zero result right away.
  `SWM_ASSERT_NEXT(a_disc_zero,
                   in_tvalid && in_tready && !in_tuser,
                   res_vld && (res_med == '0),
                   "disconnected word did not give a zero result")
  // No new word is taken while a finished result still waits for the output register.
  `SWM_ASSERT_NOW(a_no_accept_pending, in_tready, !res_vld,
                  "input accepted with a result pending")
  // The output register only fills from a completed hand-off.
  `SWM_ASSERT_NOW(a_out_from_result, $rose(out_tvalid), $past(res_vld),
                  "output word appeared without a result")

endmodule

/* tb/tb_sliding_window_median.sv */
module tb_sliding_window_median;
  timeunit 1ns;
  timeprecision 1ps;

  // Window length of the device under test; the predictor follows it.
  localparam int WIN = swm_pkg::WIN_LEN_DEF;
  localparam int VAL_W = swm_pkg::VAL_W;
  localparam int AGE_W = $clog2(WIN);
  localparam int MID = WIN / 2;

  // Values of the link status carried in in_tuser.
  localparam bit LINK_DOWN = 1'b0;
  localparam bit LINK_UP = 1'b1;

  // Random words per idling phase, and the length of the deliberate output stall.
  localparam int RAND_PER_PHASE = 370;
  localparam int LONG_STALL = 400;
  // Settling time after the last median, a little beyond one connected word.
  localparam int DRAIN_CYCLES = 2 * WIN + 8;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // in_tdata: sample_value [15:0]
  logic signed [VAL_W-1:0] in_tdata;
  // in_tuser: sensor_connected [0]
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  // out_tdata: median_out [15:0]
  logic signed [VAL_W-1:0] out_tdata;

  sliding_window_median #(
    .WIN_LEN(WIN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // One row of the directed part. Where has_median is set, the median is
  // known by inspection and is checked as typed; otherwise the predictor
  // supplies it.
  typedef struct packed {
    bit                      link;
    logic signed [VAL_W-1:0] sample;
    bit                      has_median;
    logic signed [VAL_W-1:0] median;
  } stim_row_t;

  localparam int DIR_N = 23;

  stim_row_t directed_rows [DIR_N] = '{
    // Word while the link is down right after reset: zero out.
    '{LINK_DOWN, 16'sh7FFF, 1'b1, 16'sh0000},
    // First connected word fills every zero entry, so the whole window is max.
    '{LINK_UP,   16'sh7FFF, 1'b1, 16'sh7FFF},
    '{LINK_DOWN, 16'sh8000, 1'b1, 16'sh0000},
    // Reconnect with no zero entry left: nothing is replaced.
    '{LINK_UP,   16'sh8000, 1'b1, 16'sh7FFF},
    // Primed from here on: the oldest entry is replaced each word.
    '{LINK_UP,   16'sh8000, 1'b0, 16'sh0000},
    // Zero samples while primed are stored like any other value.
    '{LINK_UP,   16'sh0000, 1'b0, 16'sh0000},
    '{LINK_UP,   16'sh0000, 1'b0, 16'sh0000},
    '{LINK_UP,   16'sh0000, 1'b0, 16'sh0000},
    '{LINK_UP,   16'sh0000, 1'b0, 16'sh0000},
    '{LINK_UP,   16'sh0000, 1'b0, 16'sh0000},
    '{LINK_DOWN, 16'sh5555, 1'b1, 16'sh0000},
    // Reconnect: only the zero entries take the new sample.
    '{LINK_UP,   16'sd100,  1'b0, 16'sh0000},
    // Equal values must not be reordered, so the ages stay attached.
    '{LINK_UP,   16'sd100,  1'b0, 16'sh0000},
    '{LINK_UP,   16'shFFFF, 1'b0, 16'sh0000},
    '{LINK_UP,   16'sh0001, 1'b0, 16'sh0000},
    '{LINK_UP,   16'shAAAA, 1'b0, 16'sh0000},
    '{LINK_UP,   16'sh5555, 1'b0, 16'sh0000},
    '{LINK_DOWN, 16'shFFFF, 1'b1, 16'sh0000},
    // A second disconnected word in a row.
    '{LINK_DOWN, 16'sh0001, 1'b1, 16'sh0000},
    // Reconnect with a zero sample leaves the window values as they are.
    '{LINK_UP,   16'sh0000, 1'b0, 16'sh0000},
    '{LINK_UP,   16'sd7,    1'b0, 16'sh0000},
    '{LINK_UP,   -16'sd7,   1'b0, 16'sh0000},
    '{LINK_UP,   16'sh7FFF, 1'b0, 16'sh0000}
  };

  // Predictor state: the window as the device should hold it, sorted
  // ascending, each value with its age tag.
  logic signed [VAL_W-1:0] win_val [WIN];
  logic [AGE_W-1:0]        win_age [WIN];
  bit                      win_primed;

  // Medians still owed by the device, oldest first.
  logic signed [VAL_W-1:0] medians_due [$];

  int errors;
  int n_linked;
  int n_dropped;
  int n_refills;
  int n_checked;
  int send_idle_pct;
  int recv_idle_pct;
  bit long_stall_req;

  // Clears the predicted window to its reset contents.
  function automatic void clear_window();
    for (int i = 0; i < WIN; i++) begin
      win_val[i] = '0;
      win_age[i] = AGE_W'(i);
    end
    win_primed = 1'b0;
  endfunction

  // Advances the predicted window by one accepted word and returns the
  // median the device has to produce for it.
  function automatic logic signed [VAL_W-1:0] next_median(bit link,
                                                          logic signed [VAL_W-1:0] sample);
    int                      j;
    logic signed [VAL_W-1:0] v;
    logic [AGE_W-1:0]        a;
    if (link == LINK_DOWN) begin
      win_primed = 1'b0;
      n_dropped++;
      return '0;
    end
    n_linked++;
    if (!win_primed) begin
      // First word after reset or a disconnect: fill the zero entries only.
      win_primed = 1'b1;
      n_refills++;
      for (int i = 0; i < WIN; i++) begin
        if (win_val[i] == 0) win_val[i] = sample;
      end
    end else begin
      // The oldest entry takes the sample and becomes the youngest.
      for (int i = 0; i < WIN; i++) begin
        if (win_age[i] == AGE_W'(WIN - 1)) begin
          win_age[i] = '0;
          win_val[i] = sample;
        end else begin
          win_age[i] = win_age[i] + 1'b1;
        end
      end
    end
    // Stable insertion sort; a strict compare keeps equal values in order.
    for (int i = 1; i < WIN; i++) begin
      v = win_val[i];
      a = win_age[i];
      j = i - 1;
      while (j >= 0 && win_val[j] > v) begin
        win_val[j + 1] = win_val[j];
        win_age[j + 1] = win_age[j];
        j--;
      end
      win_val[j + 1] = v;
      win_age[j + 1] = a;
    end
    return win_val[MID];
  endfunction

  // Random sample mix: extremes and zero often, a narrow band around zero
  // so that ties and zero entries are common, and full-range values.
  function automatic logic signed [VAL_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3, 4, 5: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one word to the device, with a random gap in front of it, and
  // records the expected median once the word is taken.
  task automatic send_word(bit link, logic signed [VAL_W-1:0] sample,
                           bit has_median, logic signed [VAL_W-1:0] median);
    logic signed [VAL_W-1:0] predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= link;
    in_tdata <= sample;
    do @(posedge clk); while (!in_tready);
    predicted = next_median(link, sample);
    medians_due.push_back(has_median ? median : predicted);
  endtask

  // Holds the sender, with nothing on offer, until the device has delivered
  // every owed median.
  task automatic wait_all_medians();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output side: random back-pressure at the current rate, plus one long
  // hold-off on request so that the block fills up and stalls its input.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_tready <= 1'b0;
        for (int k = 1; k < LONG_STALL; k++) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Scoreboard: every median word taken is compared with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (medians_due.size() == 0) begin
        $error("median_out: unexpected word, actual %0d", out_tdata);
        errors++;
      end else begin
        if (out_tdata !== medians_due[0]) begin
          $error("median_out mismatch: expected %0d, actual %0d",
                 medians_due[0], out_tdata);
          errors++;
        end
        void'(medians_due.pop_front());
        n_checked++;
      end
    end
  end

  // Hard limit well beyond the slowest correct run.
  initial begin
    #1ms;
    $display("sliding_window_median test failed");
    $finish;
  end

  initial begin
    int drop_left;
    errors = 0;
    n_linked = 0;
    n_dropped = 0;
    n_refills = 0;
    n_checked = 0;
    drop_left = 0;
    long_stall_req = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clear_window();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = LINK_DOWN;
    in_tdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with light idling so its words see some back-pressure.
    send_idle_pct = 7;
    recv_idle_pct = 45;
    for (int r = 0; r < DIR_N; r++) begin
      send_word(directed_rows[r].link, directed_rows[r].sample,
                directed_rows[r].has_median, directed_rows[r].median);
    end
    wait_all_medians();

    // Random part in three idling phases: sender rarely idle and receiver
    // often, then the reverse, then both at full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // The receiver stops for a long while as the sender keeps offering.
        if (phase == 2 && k == 100) long_stall_req = 1'b1;
        // Disconnects come as short runs of one to three words.
        if (drop_left == 0 && $urandom_range(99) < 6) drop_left = $urandom_range(3, 1);
        if (drop_left > 0) begin
          drop_left--;
          send_word(LINK_DOWN, rand_sample(), 1'b0, '0);
        end else begin
          send_word(LINK_UP, rand_sample(), 1'b0, '0);
        end
      end
      // The sender pauses here until the device has caught up.
      wait_all_medians();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_all_medians();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (medians_due.size() != 0) begin
      $error("median_out: %0d expected words never arrived", medians_due.size());
      errors++;
    end
    $display("Covered %0d connected words (%0d refills after reset or a drop) and %0d",
             n_linked, n_refills, n_dropped);
    $display("disconnected words; %0d medians checked under mixed back-pressure.",
             n_checked);
    if (errors == 0) begin
      $display("sliding_window_median test passed");
    end else begin
      $display("sliding_window_median test failed");
    end
    $finish;
  end

endmodule
